// ===== rtl/mm_pkg.sv =====
// shared widths, opcodes, register indexes and control structs for matrix_multiply
// no dependencies
`default_nettype none

package mm_pkg;

    // field widths fixed by the item formats
    localparam int OPC_W      = 2;
    localparam int POS_W      = 3;
    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // default parameter values
    localparam int DEF_MAX_DIM   = 8;
    localparam int DEF_FRAC_BITS = 16;

    // reset value of the dimension registers
    localparam logic [CFG_DATA_W-1:0] CFG_DIM_RESET = 4'd8;

    // item opcodes
    localparam logic [OPC_W-1:0] OP_WRITE_A = 2'd0;
    localparam logic [OPC_W-1:0] OP_WRITE_B = 2'd1;
    localparam logic [OPC_W-1:0] OP_COMPUTE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic wr_a;     // write element store a
        logic wr_b;     // write element store b
        logic issue;    // read one term of the dot product
        logic first;    // issued term starts a new sum
        logic load_out; // move the finished sum into the output register
        logic last;     // loaded element is the final one
    } t_dp_ctl;

    // datapath to controller status
    typedef struct packed {
        logic busy;      // terms still in the read/multiply/accumulate pipe
        logic out_stall; // output register full and not taken this cycle
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/mm_if.sv =====
// handshake channel interfaces for matrix_multiply: items in, results out, configuration
// depends on mm_pkg
`default_nettype none

interface mm_item_if;
    logic                                 valid;
    logic                                 ready;
    logic        [mm_pkg::OPC_W-1:0]      opcode;
    logic        [mm_pkg::POS_W-1:0]      row_index;
    logic        [mm_pkg::POS_W-1:0]      col_index;
    logic signed [mm_pkg::DATA_W-1:0]     element_value;

    modport source (output valid, opcode, row_index, col_index, element_value, input ready);
    modport sink   (input valid, opcode, row_index, col_index, element_value, output ready);
endinterface

interface mm_result_if;
    logic                                 valid;
    logic                                 ready;
    logic        [mm_pkg::POS_W-1:0]      out_row;
    logic        [mm_pkg::POS_W-1:0]      out_col;
    logic signed [mm_pkg::DATA_W-1:0]     product_value;
    logic                                 last;

    modport source (output valid, out_row, out_col, product_value, last, input ready);
    modport sink   (input valid, out_row, out_col, product_value, last, output ready);
endinterface

interface mm_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic        [mm_pkg::CFG_IDX_W-1:0]  reg_index;
    logic        [mm_pkg::CFG_DATA_W-1:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/mm_datapath.sv =====
// element stores, multiply-accumulate pipe, saturation and output register
// depends on mm_pkg
`default_nettype none

module mm_datapath #(
    parameter int MAX_DIM   = mm_pkg::DEF_MAX_DIM,
    parameter int FRAC_BITS = mm_pkg::DEF_FRAC_BITS,
    localparam int IDX_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire mm_pkg::t_dp_ctl               i_ctl,
    output mm_pkg::t_dp_sts                    o_sts,
    input  wire        [mm_pkg::POS_W-1:0]     i_row_index,
    input  wire        [mm_pkg::POS_W-1:0]     i_col_index,
    input  wire signed [mm_pkg::DATA_W-1:0]    i_element_value,
    input  wire        [IDX_W-1:0]             i_i,
    input  wire        [IDX_W-1:0]             i_j,
    input  wire        [IDX_W-1:0]             i_k,
    input  wire                                i_out_ready,
    output logic                               o_out_valid,
    output logic       [mm_pkg::POS_W-1:0]     o_out_row,
    output logic       [mm_pkg::POS_W-1:0]     o_out_col,
    output logic signed [mm_pkg::DATA_W-1:0]   o_product_value,
    output logic                               o_last
);

    localparam int NSLOTS = MAX_DIM * MAX_DIM;
    localparam int AW     = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
    localparam int PROD_W = 2 * mm_pkg::DATA_W;
    localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;
    localparam int DW     = mm_pkg::DATA_W;

    logic [DW-1:0] mem_a [NSLOTS];
    logic [DW-1:0] mem_b [NSLOTS];

    logic [AW-1:0] w_wr_addr;
    logic [AW-1:0] w_rd_addr_a;
    logic [AW-1:0] w_rd_addr_b;

    logic signed [DW-1:0]     r_rd_a;
    logic signed [DW-1:0]     r_rd_b;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_v1;
    logic                     r_f1;
    logic                     r_v2;
    logic                     r_f2;

    logic signed [ACC_W-1:0]  w_shift;
    logic [ACC_W-DW:0]        w_hi;
    logic signed [DW-1:0]     w_sat;

    logic                     r_out_valid;
    logic [mm_pkg::POS_W-1:0] r_out_row;
    logic [mm_pkg::POS_W-1:0] r_out_col;
    logic signed [DW-1:0]     r_out_val;
    logic                     r_out_last;

    // row-major addressing, row * MAX_DIM + column
    assign w_wr_addr   = AW'(32'(i_row_index) * MAX_DIM + 32'(i_col_index));
    assign w_rd_addr_a = AW'(32'(i_i) * MAX_DIM + 32'(i_k));
    assign w_rd_addr_b = AW'(32'(i_k) * MAX_DIM + 32'(i_j));

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_a) begin
            mem_a[w_wr_addr] <= i_element_value;
        end
        if (i_ctl.issue) begin
            r_rd_a <= mem_a[w_rd_addr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_b) begin
            mem_b[w_wr_addr] <= i_element_value;
        end
        if (i_ctl.issue) begin
            r_rd_b <= mem_b[w_rd_addr_b];
        end
    end

    // product and accumulate stages
    always_ff @(posedge i_clk) begin
        r_prod <= r_rd_a * r_rd_b;
        if (r_v2) begin
            r_acc <= (r_f2 ? ACC_W'(0) : r_acc) + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_f1 <= 1'b0;
            r_v2 <= 1'b0;
            r_f2 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.issue;
            r_f1 <= i_ctl.first;
            r_v2 <= r_v1;
            r_f2 <= r_f1;
        end
    end

    // drop fraction bits (floor), then clamp to 32 bits
    always_comb begin
        w_shift = r_acc >>> FRAC_BITS;
        w_hi    = w_shift[ACC_W-1:DW-1];
        if ((&w_hi) || !(|w_hi)) begin
            w_sat = w_shift[DW-1:0];
        end else if (w_shift[ACC_W-1]) begin
            w_sat = {1'b1, {(DW-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(DW-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            r_out_row  <= mm_pkg::POS_W'(i_i);
            r_out_col  <= mm_pkg::POS_W'(i_j);
            r_out_val  <= w_sat;
            r_out_last <= i_ctl.last;
        end
    end

    assign o_sts.busy      = r_v1 | r_v2;
    assign o_sts.out_stall = r_out_valid & ~i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_out_row       = r_out_row;
    assign o_out_col       = r_out_col;
    assign o_product_value = r_out_val;
    assign o_last          = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/mm_controller.sv =====
// dimension registers and the state machine that sequences loads and the product walk
// depends on mm_pkg
`default_nettype none

module mm_controller #(
    parameter int MAX_DIM = mm_pkg::DEF_MAX_DIM,
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_item_valid,
    output logic                              o_item_ready,
    input  wire  [mm_pkg::OPC_W-1:0]          i_opcode,
    input  wire  [mm_pkg::POS_W-1:0]          i_row_index,
    input  wire  [mm_pkg::POS_W-1:0]          i_col_index,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [mm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [mm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire mm_pkg::t_dp_sts              i_sts,
    output mm_pkg::t_dp_ctl                   o_ctl,
    output logic [IDX_W-1:0]                  o_i,
    output logic [IDX_W-1:0]                  o_j,
    output logic [IDX_W-1:0]                  o_k
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CW    = (DIM_W > mm_pkg::CFG_DATA_W) ? DIM_W : mm_pkg::CFG_DATA_W;
    localparam int PW    = (DIM_W > mm_pkg::POS_W) ? DIM_W : mm_pkg::POS_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_ISSUE  = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_RESULT = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_j, n_j;
    logic [IDX_W-1:0] r_k, n_k;

    logic [mm_pkg::CFG_DATA_W-1:0] r_rows_a;
    logic [mm_pkg::CFG_DATA_W-1:0] r_inner_dim;
    logic [mm_pkg::CFG_DATA_W-1:0] r_cols_b;

    logic [DIM_W-1:0] w_m;
    logic [DIM_W-1:0] w_n;
    logic [DIM_W-1:0] w_p;
    logic             w_accept;
    logic             w_k_end;
    logic             w_j_end;
    logic             w_i_end;
    logic             w_row_ok_a;
    logic             w_col_ok_a;
    logic             w_row_ok_b;
    logic             w_col_ok_b;

    // configuration registers, index beyond the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= mm_pkg::CFG_DIM_RESET;
            r_inner_dim <= mm_pkg::CFG_DIM_RESET;
            r_cols_b    <= mm_pkg::CFG_DIM_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mm_pkg::CFG_ROWS_A:    r_rows_a    <= i_cfg_data;
                mm_pkg::CFG_INNER_DIM: r_inner_dim <= i_cfg_data;
                mm_pkg::CFG_COLS_B:    r_cols_b    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // zero reads as one, above MAX_DIM reads as MAX_DIM
    always_comb begin
        if (r_rows_a == '0) begin
            w_m = DIM_W'(1);
        end else if (CW'(r_rows_a) > CW'(MAX_DIM)) begin
            w_m = DIM_W'(MAX_DIM);
        end else begin
            w_m = DIM_W'(r_rows_a);
        end
        if (r_inner_dim == '0) begin
            w_n = DIM_W'(1);
        end else if (CW'(r_inner_dim) > CW'(MAX_DIM)) begin
            w_n = DIM_W'(MAX_DIM);
        end else begin
            w_n = DIM_W'(r_inner_dim);
        end
        if (r_cols_b == '0) begin
            w_p = DIM_W'(1);
        end else if (CW'(r_cols_b) > CW'(MAX_DIM)) begin
            w_p = DIM_W'(MAX_DIM);
        end else begin
            w_p = DIM_W'(r_cols_b);
        end
    end

    assign w_row_ok_a = PW'(i_row_index) < PW'(w_m);
    assign w_col_ok_a = PW'(i_col_index) < PW'(w_n);
    assign w_row_ok_b = PW'(i_row_index) < PW'(w_n);
    assign w_col_ok_b = PW'(i_col_index) < PW'(w_p);

    assign w_accept = i_item_valid && (r_state == S_IDLE);
    assign w_k_end  = (DIM_W'(r_k) + DIM_W'(1)) == w_n;
    assign w_j_end  = (DIM_W'(r_j) + DIM_W'(1)) == w_p;
    assign w_i_end  = (DIM_W'(r_i) + DIM_W'(1)) == w_m;

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_ctl.wr_a = (i_opcode == mm_pkg::OP_WRITE_A) && w_row_ok_a && w_col_ok_a;
                    o_ctl.wr_b = (i_opcode == mm_pkg::OP_WRITE_B) && w_row_ok_b && w_col_ok_b;
                    if (i_opcode == mm_pkg::OP_COMPUTE) begin
                        n_i     = '0;
                        n_j     = '0;
                        n_k     = '0;
                        n_state = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                o_ctl.issue = 1'b1;
                o_ctl.first = (r_k == '0);
                if (w_k_end) begin
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                if (!i_sts.busy) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!i_sts.out_stall) begin
                    o_ctl.load_out = 1'b1;
                    o_ctl.last     = w_i_end && w_j_end;
                    n_k            = '0;
                    if (w_i_end && w_j_end) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_ISSUE;
                        if (w_j_end) begin
                            n_j = '0;
                            n_i = r_i + IDX_W'(1);
                        end else begin
                            n_j = r_j + IDX_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    assign o_item_ready = (r_state == S_IDLE);
    assign o_i          = r_i;
    assign o_j          = r_j;
    assign o_k          = r_k;

endmodule

`default_nettype wire

// ===== rtl/matrix_multiply.sv =====
// matrix_multiply top level: joins the controller and the datapath to the channel interfaces
// depends on mm_pkg, mm_if, mm_controller, mm_datapath
//
// fixed-point matrix product c = a * b. items with opcode write a / write b load one signed
// q16.16 element each into store a or store b at row * MAX_DIM + column, one item a cycle;
// a load whose row or column lies outside the current dimensions is dropped, as is an item
// with the unused opcode. a compute item walks the product in row-major order and gives one
// result item per element, flagged last on the final one. each element is summed exactly,
// floored by FRAC_BITS fraction bits and clamped to 32 bits. the stores have no reset: every
// entry that a compute reads must have been loaded first. one multiply-accumulate unit does
// the work: for each element it reads the stores once per term, drains the read, multiply
// and accumulate stages, then clamps the sum into the output register; the walk waits while
// a result is not taken. no item is accepted during a compute; the item after it may be
// taken while its final result still waits in the output register. dimension registers of
// zero act as one and values above MAX_DIM act as MAX_DIM; write them only while the block
// is idle.
`default_nettype none

module matrix_multiply #(
    parameter int MAX_DIM   = mm_pkg::DEF_MAX_DIM,
    parameter int FRAC_BITS = mm_pkg::DEF_FRAC_BITS
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    mm_item_if.sink      i_item,
    mm_result_if.source  o_result,
    mm_cfg_if.sink       i_cfg
);

    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    mm_pkg::t_dp_ctl  w_ctl;
    mm_pkg::t_dp_sts  w_sts;
    logic [IDX_W-1:0] w_i;
    logic [IDX_W-1:0] w_j;
    logic [IDX_W-1:0] w_k;
    logic             w_item_ready;
    logic             w_cfg_ready;

    // sequencing: dimension registers, load decode and the element walk
    mm_controller #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item.valid),
        .o_item_ready (w_item_ready),
        .i_opcode     (i_item.opcode),
        .i_row_index  (i_item.row_index),
        .i_col_index  (i_item.col_index),
        .i_cfg_valid  (i_cfg.valid),
        .o_cfg_ready  (w_cfg_ready),
        .i_cfg_index  (i_cfg.reg_index),
        .i_cfg_data   (i_cfg.wr_data),
        .i_sts        (w_sts),
        .o_ctl        (w_ctl),
        .o_i          (w_i),
        .o_j          (w_j),
        .o_k          (w_k)
    );

    // stores, mac pipe and output register
    mm_datapath #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl),
        .o_sts           (w_sts),
        .i_row_index     (i_item.row_index),
        .i_col_index     (i_item.col_index),
        .i_element_value (i_item.element_value),
        .i_i             (w_i),
        .i_j             (w_j),
        .i_k             (w_k),
        .i_out_ready     (o_result.ready),
        .o_out_valid     (o_result.valid),
        .o_out_row       (o_result.out_row),
        .o_out_col       (o_result.out_col),
        .o_product_value (o_result.product_value),
        .o_last          (o_result.last)
    );

    assign i_item.ready = w_item_ready;
    assign i_cfg.ready  = w_cfg_ready;

    // no item taken while terms are being read
    a_no_accept_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.issue |-> !w_item_ready)
        else $error("item accepted during product walk");

    // a sum is clamped only once the mac pipe has drained
    a_load_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.load_out |-> !w_sts.busy)
        else $error("result loaded with terms still in flight");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.out_stall |-> !w_ctl.load_out)
        else $error("output register overwritten while stalled");

    // final element shows up flagged
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.load_out && w_ctl.last) |=> (o_result.valid && o_result.last))
        else $error("final element not flagged last");

endmodule

`default_nettype wire
